// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL core.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a property holds at every rising clock edge outside reset.
`define SMMA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define SMMA_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define SMMA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define SMMA_ASSERT(lbl, clk, rst, prop, msg)
`define SMMA_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define SMMA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// File: rtl/core/smma_pkg.sv
// Constants, types and sequencer states of the sample aggregator.
// Depends on nothing; imported by the divider and the top level.
package smma_pkg;

   localparam int unsigned COUNT_LIMIT    = 65535;
   localparam int unsigned CountWidth     = $clog2(COUNT_LIMIT + 1);
   localparam int unsigned SumWidth       = 18 + CountWidth;
   localparam int unsigned DividendWidth  = SumWidth + 1;
   localparam int unsigned DivisorWidth   = CountWidth + 1;
   localparam int unsigned StepWidth      = $clog2(DividendWidth);

   localparam int unsigned OXY_CLAMP  = 65000;
   localparam int unsigned SAT_CLAMP  = 65500;
   localparam int signed   TEMP_CLAMP = 30000;
   localparam int unsigned TOTAL_CAP  = 255;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_OXY,
      ST_DIV_SAT,
      ST_LOAD
   } smma_state_type;

   typedef struct packed {
      logic start;
   } smma_div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } smma_div_stat_type;

endpackage

// File: rtl/core/smma_req_if.sv
// Request and result channel interfaces of the sample aggregator.
// Depends on nothing; used by the top level ports.
interface smma_req_if;
   logic               valid;
   logic               ready;
   logic               kind;
   logic signed [17:0] oxygen_value;
   logic signed [17:0] saturation_value;
   logic signed [16:0] temperature_value;
   logic        [7:0]  level_value;
   logic        [31:0] bucket_time;

   modport source (
      output valid, kind, oxygen_value, saturation_value, temperature_value,
             level_value, bucket_time,
      input  ready
   );
   modport sink (
      input  valid, kind, oxygen_value, saturation_value, temperature_value,
             level_value, bucket_time,
      output ready
   );
endinterface

interface smma_rsp_if;
   logic               valid;
   logic               ready;
   logic               has_data;
   logic        [31:0] bucket_stamp;
   logic        [15:0] oxygen_min;
   logic        [15:0] oxygen_avg;
   logic        [15:0] oxygen_max;
   logic        [15:0] saturation_avg;
   logic signed [15:0] temperature_min;
   logic signed [15:0] temperature_max;
   logic        [7:0]  level_peak;
   logic        [7:0]  sample_total;

   modport source (
      output valid, has_data, bucket_stamp, oxygen_min, oxygen_avg, oxygen_max,
             saturation_avg, temperature_min, temperature_max, level_peak,
             sample_total,
      input  ready
   );
   modport sink (
      input  valid, has_data, bucket_stamp, oxygen_min, oxygen_avg, oxygen_max,
             saturation_avg, temperature_min, temperature_max, level_peak,
             sample_total,
      output ready
   );
endinterface

// File: rtl/core/smma_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on smma_pkg for widths and the control and status structs.
module smma_div
   import smma_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  smma_div_ctrl_type         ctrl,
   input  logic [DividendWidth-1:0]  dividend,
   input  logic [DivisorWidth-1:0]   divisor,
   output smma_div_stat_type         stat,
   output logic [DividendWidth-1:0]  quotient
);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [StepWidth-1:0]      step_ff, step_in;
   logic [DivisorWidth-1:0]   rem_ff, rem_in;
   logic [DividendWidth-1:0]  quo_ff, quo_in;
   logic [DivisorWidth-1:0]   dsr_ff, dsr_in;
   logic [DivisorWidth:0]     trial;
   logic                      fits;

   // Shift in the next dividend bit; keep the subtraction when it fits.
   assign trial = {rem_ff, quo_ff[DividendWidth-1]};
   assign fits  = (trial >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         step_in = StepWidth'(DividendWidth - 1);
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = DivisorWidth'(trial - {1'b0, dsr_ff});
         end else begin
            rem_in = DivisorWidth'(trial);
         end
         quo_in = {quo_ff[DividendWidth-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dsr_ff  <= dsr_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

// File: rtl/core/sample_min_max_mean_aggregator.sv
// Sample min / max / mean aggregator: folds fixed-point sensor samples into an
// open bucket and emits one clamped aggregate per flush beat. A sample beat
// updates count, oxygen min/max/sum, saturation sum, temperature min/max and
// level peak at once; samples beyond COUNT_LIMIT are dropped. A flush beat
// runs two rounded-half-up means, (2*sum + n) / (2*n), through one shared
// restoring divider that retires one quotient bit a cycle, so a flush on a
// non-empty bucket holds the request side until both divisions end and its
// result loads, and an empty flush until its result loads. The divider and
// the output register are the rate-setting elements. The result sits in the
// output register; while it waits, sample beats are still taken, and a
// further flush computes and then holds until the slot frees.
// Depends on smma_pkg, the channel interfaces, smma_div and assert_macros.svh.
`include "assert_macros.svh"

module sample_min_max_mean_aggregator
   import smma_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   smma_req_if.sink    req_bus,
   smma_rsp_if.source  rsp_bus
);

   // Sequencer
   smma_state_type state_ff, state_in;

   // Bucket state
   logic [CountWidth-1:0]      count_ff, count_in;
   logic signed [17:0]         oxy_low_ff, oxy_low_in;
   logic signed [17:0]         oxy_high_ff, oxy_high_in;
   logic signed [SumWidth-1:0] oxy_sum_ff, oxy_sum_in;
   logic signed [SumWidth-1:0] sat_sum_ff, sat_sum_in;
   logic signed [16:0]         tmp_low_ff, tmp_low_in;
   logic signed [16:0]         tmp_high_ff, tmp_high_in;
   logic [7:0]                 lvl_high_ff, lvl_high_in;

   // Flush work registers
   logic [31:0] stamp_ff, stamp_in;
   logic [15:0] oxy_avg_ff, oxy_avg_in;
   logic [15:0] sat_avg_ff, sat_avg_in;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               has_data_ff;
   logic [31:0]        bucket_stamp_ff;
   logic [15:0]        oxy_min_ff, oxy_avg_out_ff, oxy_max_ff, sat_avg_out_ff;
   logic signed [15:0] tmp_min_ff, tmp_max_ff;
   logic [7:0]         lvl_peak_ff, total_ff;

   logic                      req_beat;
   logic                      sample_beat;
   logic                      flush_beat;
   logic                      bucket_empty;
   logic                      slot_free;
   logic                      load_rsp;
   smma_div_ctrl_type         div_ctrl;
   smma_div_stat_type         div_stat;
   logic [SumWidth-1:0]       div_sum;
   logic [DividendWidth-1:0]  div_dividend;
   logic [DivisorWidth-1:0]   div_divisor;
   logic [DividendWidth-1:0]  div_quotient;
   logic                      oxy_sum_pos;
   logic                      sat_sum_pos;

   // Clamp a signed reading to 0..hi.
   function automatic logic [15:0] clamp_unsigned(logic signed [17:0] v,
                                                  logic [15:0] hi);
      logic [15:0] res;
      if (v < 0) begin
         res = '0;
      end else if (v > $signed({2'b00, hi})) begin
         res = hi;
      end else begin
         res = v[15:0];
      end
      return res;
   endfunction

   // Clamp a temperature to the symmetric output range.
   function automatic logic signed [15:0] clamp_temp(logic signed [16:0] v);
      logic signed [15:0] res;
      if (v < -17'(TEMP_CLAMP)) begin
         res = -16'(TEMP_CLAMP);
      end else if (v > 17'(TEMP_CLAMP)) begin
         res = 16'(TEMP_CLAMP);
      end else begin
         res = v[15:0];
      end
      return res;
   endfunction

   // Limit a divider quotient; a mean of a non-positive sum reads as zero.
   function automatic logic [15:0] clamp_mean(logic [DividendWidth-1:0] q,
                                              logic pos, logic [15:0] hi);
      logic [15:0] res;
      if (!pos) begin
         res = '0;
      end else if (q > DividendWidth'(hi)) begin
         res = hi;
      end else begin
         res = q[15:0];
      end
      return res;
   endfunction

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_beat      = req_bus.valid && req_bus.ready;
   assign sample_beat   = req_beat && !req_bus.kind;
   assign flush_beat    = req_beat && req_bus.kind;
   assign bucket_empty  = (count_ff == '0);
   assign slot_free     = !rsp_valid_ff || rsp_bus.ready;

   assign oxy_sum_pos = !oxy_sum_ff[SumWidth-1] && (oxy_sum_ff != '0);
   assign sat_sum_pos = !sat_sum_ff[SumWidth-1] && (sat_sum_ff != '0);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (flush_beat) begin
               state_in = bucket_empty ? ST_LOAD : ST_DIV_OXY;
            end
         end
         ST_DIV_OXY: begin
            if (div_stat.done) begin
               state_in = ST_DIV_SAT;
            end
         end
         ST_DIV_SAT: begin
            if (div_stat.done) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: oxygen division starts on a flush beat to a non-empty bucket,
   // saturation division as the oxygen one finishes; load once the slot frees.
   always_comb begin
      div_ctrl.start = 1'b0;
      div_sum        = sat_sum_ff;
      load_rsp       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            div_ctrl.start = flush_beat && !bucket_empty;
            div_sum        = oxy_sum_ff;
         end
         ST_DIV_OXY: begin
            div_ctrl.start = div_stat.done;
         end
         ST_DIV_SAT: begin
         end
         ST_LOAD: begin
            load_rsp = slot_free;
         end
         default: begin
         end
      endcase
   end

   // Rounded mean: (2*sum + n) / (2*n). Only used when the sum is positive.
   assign div_dividend = DividendWidth'({1'b0, div_sum} << 1)
                       + DividendWidth'(count_ff);
   assign div_divisor  = {count_ff, 1'b0};

   smma_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quotient)
   );

   // Bucket update on a sample beat; the first sample restarts everything.
   always_comb begin
      count_in    = count_ff;
      oxy_low_in  = oxy_low_ff;
      oxy_high_in = oxy_high_ff;
      oxy_sum_in  = oxy_sum_ff;
      sat_sum_in  = sat_sum_ff;
      tmp_low_in  = tmp_low_ff;
      tmp_high_in = tmp_high_ff;
      lvl_high_in = lvl_high_ff;
      if (sample_beat && (count_ff < CountWidth'(COUNT_LIMIT))) begin
         count_in = count_ff + 1'b1;
         if (bucket_empty) begin
            oxy_low_in  = req_bus.oxygen_value;
            oxy_high_in = req_bus.oxygen_value;
            tmp_low_in  = req_bus.temperature_value;
            tmp_high_in = req_bus.temperature_value;
            oxy_sum_in  = SumWidth'(req_bus.oxygen_value);
            sat_sum_in  = SumWidth'(req_bus.saturation_value);
            lvl_high_in = req_bus.level_value;
         end else begin
            if (req_bus.oxygen_value < oxy_low_ff) begin
               oxy_low_in = req_bus.oxygen_value;
            end
            if (req_bus.oxygen_value > oxy_high_ff) begin
               oxy_high_in = req_bus.oxygen_value;
            end
            if (req_bus.temperature_value < tmp_low_ff) begin
               tmp_low_in = req_bus.temperature_value;
            end
            if (req_bus.temperature_value > tmp_high_ff) begin
               tmp_high_in = req_bus.temperature_value;
            end
            if (req_bus.level_value > lvl_high_ff) begin
               lvl_high_in = req_bus.level_value;
            end
            oxy_sum_in = oxy_sum_ff + SumWidth'(req_bus.oxygen_value);
            sat_sum_in = sat_sum_ff + SumWidth'(req_bus.saturation_value);
         end
      end
      // Drop the bucket once its aggregate lands in the output register.
      if (load_rsp) begin
         count_in = '0;
      end
   end

   // Flush work registers: stamp on the flush beat, means as divisions end.
   always_comb begin
      stamp_in   = stamp_ff;
      oxy_avg_in = oxy_avg_ff;
      sat_avg_in = sat_avg_ff;
      if (flush_beat) begin
         stamp_in = req_bus.bucket_time;
      end
      if (div_stat.done && (state_ff == ST_DIV_OXY)) begin
         oxy_avg_in = clamp_mean(div_quotient, oxy_sum_pos, 16'(OXY_CLAMP));
      end
      if (div_stat.done && (state_ff == ST_DIV_SAT)) begin
         sat_avg_in = clamp_mean(div_quotient, sat_sum_pos, 16'(SAT_CLAMP));
      end
   end

   // Output valid: set on load, drop on a taken beat.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      oxy_low_ff  <= oxy_low_in;
      oxy_high_ff <= oxy_high_in;
      oxy_sum_ff  <= oxy_sum_in;
      sat_sum_ff  <= sat_sum_in;
      tmp_low_ff  <= tmp_low_in;
      tmp_high_ff <= tmp_high_in;
      lvl_high_ff <= lvl_high_in;
      stamp_ff    <= stamp_in;
      oxy_avg_ff  <= oxy_avg_in;
      sat_avg_ff  <= sat_avg_in;
   end

   // Output payload register; an empty bucket reports zeros beside its stamp.
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         bucket_stamp_ff <= stamp_ff;
         if (bucket_empty) begin
            has_data_ff    <= 1'b0;
            oxy_min_ff     <= '0;
            oxy_avg_out_ff <= '0;
            oxy_max_ff     <= '0;
            sat_avg_out_ff <= '0;
            tmp_min_ff     <= '0;
            tmp_max_ff     <= '0;
            lvl_peak_ff    <= '0;
            total_ff       <= '0;
         end else begin
            has_data_ff    <= 1'b1;
            oxy_min_ff     <= clamp_unsigned(oxy_low_ff, 16'(OXY_CLAMP));
            oxy_avg_out_ff <= oxy_avg_ff;
            oxy_max_ff     <= clamp_unsigned(oxy_high_ff, 16'(OXY_CLAMP));
            sat_avg_out_ff <= sat_avg_ff;
            tmp_min_ff     <= clamp_temp(tmp_low_ff);
            tmp_max_ff     <= clamp_temp(tmp_high_ff);
            lvl_peak_ff    <= lvl_high_ff;
            if (count_ff > CountWidth'(TOTAL_CAP)) begin
               total_ff <= 8'(TOTAL_CAP);
            end else begin
               total_ff <= count_ff[7:0];
            end
         end
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.has_data        = has_data_ff;
   assign rsp_bus.bucket_stamp    = bucket_stamp_ff;
   assign rsp_bus.oxygen_min      = oxy_min_ff;
   assign rsp_bus.oxygen_avg      = oxy_avg_out_ff;
   assign rsp_bus.oxygen_max      = oxy_max_ff;
   assign rsp_bus.saturation_avg  = sat_avg_out_ff;
   assign rsp_bus.temperature_min = tmp_min_ff;
   assign rsp_bus.temperature_max = tmp_max_ff;
   assign rsp_bus.level_peak      = lvl_peak_ff;
   assign rsp_bus.sample_total    = total_ff;

   // Checks
   `SMMA_ASSERT(a_count_limit, clock, reset, count_ff <= CountWidth'(COUNT_LIMIT), "count past limit")
   `SMMA_ASSERT_IMPLY(a_div_start_idle, clock, reset, div_ctrl.start, !div_stat.busy, "divider restarted while busy")
   `SMMA_ASSERT_NEXT(a_flush_blocks, clock, reset, flush_beat, !req_bus.ready, "request taken during flush")
   `SMMA_ASSERT_IMPLY(a_oxy_order, clock, reset, !bucket_empty, oxy_low_ff <= oxy_high_ff, "oxygen min above max")

endmodule

// File: verif/smma_beat_pkg.sv
// Beat and aggregate types shared by the aggregator testbench and its checker.
// Depends on nothing; imported by the checker and the testbench top.
`timescale 1ns / 100ps

package smma_beat_pkg;

   typedef enum logic {
      BEAT_SAMPLE = 1'b0,
      BEAT_FLUSH  = 1'b1
   } beat_kind_type;

   typedef struct packed {
      beat_kind_type      kind;
      logic signed [17:0] oxygen;
      logic signed [17:0] saturation;
      logic signed [16:0] temperature;
      logic        [7:0]  level;
      logic        [31:0] stamp;
   } sensor_beat_type;

   typedef struct packed {
      logic               has_data;
      logic        [31:0] bucket_stamp;
      logic        [15:0] oxygen_min;
      logic        [15:0] oxygen_avg;
      logic        [15:0] oxygen_max;
      logic        [15:0] saturation_avg;
      logic signed [15:0] temperature_min;
      logic signed [15:0] temperature_max;
      logic        [7:0]  level_peak;
      logic        [7:0]  sample_total;
   } aggregate_type;

endpackage

// File: verif/sample_min_max_mean_aggregator_checker.sv
// Bucket predictor and result scoreboard for the sample aggregator.
// Depends on smma_pkg, smma_beat_pkg and the request and result interfaces.
`timescale 1ns / 100ps

module sample_min_max_mean_aggregator_checker
   import smma_pkg::*;
   import smma_beat_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   smma_req_if         req_mon,
   smma_rsp_if         rsp_mon,
   output int unsigned mismatch_count,
   output int unsigned pending_count
);

   // open bucket as the block should hold it
   int unsigned bucket_count;
   int          oxy_low;
   int          oxy_high;
   int          temp_low;
   int          temp_high;
   longint      oxy_sum;
   longint      sat_sum;
   logic [7:0]  level_high;

   aggregate_type aggregates_due[$];
   int unsigned   misses;
   int unsigned   results_seen;

   function automatic logic [15:0] clamp_reading(int v, int ceiling);
      if (v < 0) return 16'd0;
      if (v > ceiling) return 16'(ceiling);
      return 16'(v);
   endfunction

   function automatic logic signed [15:0] clamp_temperature(int t);
      if (t < -TEMP_CLAMP) return 16'(-TEMP_CLAMP);
      if (t > TEMP_CLAMP) return 16'(TEMP_CLAMP);
      return 16'(t);
   endfunction

   // (2*sum + n) / (2*n), i.e. the mean rounded half up
   function automatic logic [15:0] rounded_mean(longint sum, int unsigned n, int ceiling);
      longint q;
      if (n == 0 || sum <= 0) return 16'd0;
      q = (sum * 2 + longint'(n)) / (longint'(n) * 2);
      if (q > ceiling) return 16'(ceiling);
      return 16'(q);
   endfunction

   function automatic void fold_sample(int oxy, int sat, int tmp, logic [7:0] lvl);
      if (bucket_count >= COUNT_LIMIT) return;
      if (bucket_count == 0) begin
         oxy_low    = oxy;
         oxy_high   = oxy;
         temp_low   = tmp;
         temp_high  = tmp;
         oxy_sum    = 0;
         sat_sum    = 0;
         level_high = 8'd0;
      end
      if (oxy < oxy_low) oxy_low = oxy;
      if (oxy > oxy_high) oxy_high = oxy;
      if (tmp < temp_low) temp_low = tmp;
      if (tmp > temp_high) temp_high = tmp;
      if (lvl > level_high) level_high = lvl;
      oxy_sum += oxy;
      sat_sum += sat;
      bucket_count++;
   endfunction

   function automatic aggregate_type close_bucket(logic [31:0] stamp);
      aggregate_type agg;
      agg = '0;
      agg.bucket_stamp = stamp;
      if (bucket_count != 0) begin
         agg.has_data        = 1'b1;
         agg.oxygen_min      = clamp_reading(oxy_low, OXY_CLAMP);
         agg.oxygen_avg      = rounded_mean(oxy_sum, bucket_count, OXY_CLAMP);
         agg.oxygen_max      = clamp_reading(oxy_high, OXY_CLAMP);
         agg.saturation_avg  = rounded_mean(sat_sum, bucket_count, SAT_CLAMP);
         agg.temperature_min = clamp_temperature(temp_low);
         agg.temperature_max = clamp_temperature(temp_high);
         agg.level_peak      = level_high;
         agg.sample_total    = bucket_count > TOTAL_CAP ? 8'(TOTAL_CAP) : 8'(bucket_count);
      end
      bucket_count = 0;
      return agg;
   endfunction

   function automatic bit field_ok(string name, int unsigned idx, longint want, longint got,
                                   bit loud);
      if (want == got) return 1'b1;
      if (loud) $display("rsp %0d %s: expected %0d, got %0d", idx, name, want, got);
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      aggregate_type want;
      bit            ok;
      bit            loud;
      if (reset) begin
         bucket_count = 0;
         oxy_low      = 0;
         oxy_high     = 0;
         temp_low     = 0;
         temp_high    = 0;
         oxy_sum      = 0;
         sat_sum      = 0;
         level_high   = 8'd0;
         misses       = 0;
         results_seen = 0;
         aggregates_due.delete();
      end else begin
         // retire a result before taking a new request
         if (rsp_mon.valid && rsp_mon.ready) begin
            loud = misses < 10;
            if (aggregates_due.size() == 0) begin
               if (loud) $display("rsp %0d: result with nothing outstanding", results_seen);
               misses++;
            end else begin
               want = aggregates_due.pop_front();
               ok = 1'b1;
               ok &= field_ok("has_data", results_seen, want.has_data, rsp_mon.has_data, loud);
               ok &= field_ok("bucket_stamp", results_seen, want.bucket_stamp,
                              rsp_mon.bucket_stamp, loud);
               ok &= field_ok("oxygen_min", results_seen, want.oxygen_min,
                              rsp_mon.oxygen_min, loud);
               ok &= field_ok("oxygen_avg", results_seen, want.oxygen_avg,
                              rsp_mon.oxygen_avg, loud);
               ok &= field_ok("oxygen_max", results_seen, want.oxygen_max,
                              rsp_mon.oxygen_max, loud);
               ok &= field_ok("saturation_avg", results_seen, want.saturation_avg,
                              rsp_mon.saturation_avg, loud);
               ok &= field_ok("temperature_min", results_seen, want.temperature_min,
                              rsp_mon.temperature_min, loud);
               ok &= field_ok("temperature_max", results_seen, want.temperature_max,
                              rsp_mon.temperature_max, loud);
               ok &= field_ok("level_peak", results_seen, want.level_peak,
                              rsp_mon.level_peak, loud);
               ok &= field_ok("sample_total", results_seen, want.sample_total,
                              rsp_mon.sample_total, loud);
               if (!ok) misses++;
            end
            results_seen++;
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.kind == BEAT_FLUSH)
               aggregates_due.push_back(close_bucket(req_mon.bucket_time));
            else
               fold_sample(req_mon.oxygen_value, req_mon.saturation_value,
                           req_mon.temperature_value, req_mon.level_value);
         end
      end
      mismatch_count <= misses;
      pending_count  <= aggregates_due.size();
   end

endmodule

// File: verif/sample_min_max_mean_aggregator_test.sv
// Testbench top for the sample aggregator: clock, reset, stimulus and verdict.
// Depends on smma_pkg, smma_beat_pkg, the channel interfaces and the checker.
`timescale 1ns / 100ps

module sample_min_max_mean_aggregator_test;
   import smma_pkg::*;
   import smma_beat_pkg::*;

   // Cycles the receiver refuses results during the back-pressure phase.
   localparam int unsigned HOLD_SPAN    = 400;
   // Beats in the randomized part and the window in it that runs without gaps.
   localparam int unsigned RANDOM_BEATS = 1400;
   localparam int unsigned STEADY_FROM  = 500;
   localparam int unsigned STEADY_TO    = 800;
   // Cycles to wait after the last result before the verdict.
   localparam int unsigned DRAIN_CYCLES = 100;
   // No handshake on either channel for this long means the block is hung.
   localparam int unsigned HANG_LIMIT   = 5000;

   logic        clock = 1'b0;
   logic        reset;
   int unsigned mismatches;
   int unsigned results_pending;
   int unsigned beats_sent = 0;
   int unsigned quiet_cycles = 0;
   int unsigned hold_ticket;
   bit          steady_req = 1'b0;
   bit          steady_rsp;

   smma_req_if req_bus ();
   smma_rsp_if rsp_bus ();

   sample_min_max_mean_aggregator u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   sample_min_max_mean_aggregator_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .mismatch_count (mismatches),
      .pending_count  (results_pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Mostly plausible readings, with a share of raw bit patterns and range corners.
   function automatic logic signed [17:0] pick_reading(int unsigned typical_top);
      case ($urandom_range(9))
         0: return 18'($urandom);
         1: begin
            case ($urandom_range(5))
               0: return 18'(-131072);
               1: return 18'(131071);
               2: return 18'(-1);
               3: return 18'(65000);
               4: return 18'(65501);
               default: return 18'(0);
            endcase
         end
         default: return 18'($urandom_range(typical_top));
      endcase
   endfunction

   function automatic sensor_beat_type rand_sample();
      sensor_beat_type beat;
      beat.kind       = BEAT_SAMPLE;
      beat.oxygen     = pick_reading(66000);
      beat.saturation = pick_reading(66500);
      case ($urandom_range(9))
         0: beat.temperature = 17'($urandom);
         1: begin
            case ($urandom_range(5))
               0: beat.temperature = 17'(-65536);
               1: beat.temperature = 17'(65535);
               2: beat.temperature = 17'(30000);
               3: beat.temperature = 17'(30001);
               4: beat.temperature = 17'(-30000);
               default: beat.temperature = 17'(-30001);
            endcase
         end
         default: beat.temperature = 17'(int'($urandom_range(64000)) - 32000);
      endcase
      beat.level = 8'($urandom);
      beat.stamp = $urandom;
      return beat;
   endfunction

   function automatic sensor_beat_type make_sample(int oxy, int sat, int tmp, int lvl);
      sensor_beat_type beat;
      beat.kind        = BEAT_SAMPLE;
      beat.oxygen      = 18'(oxy);
      beat.saturation  = 18'(sat);
      beat.temperature = 17'(tmp);
      beat.level       = 8'(lvl);
      beat.stamp       = $urandom;
      return beat;
   endfunction

   function automatic sensor_beat_type make_flush(logic [31:0] stamp);
      sensor_beat_type beat;
      beat             = rand_sample();
      beat.kind        = BEAT_FLUSH;
      beat.stamp       = stamp;
      return beat;
   endfunction

   // Offer one beat and return at the edge that takes it. Valid is left high so
   // that back-to-back beats never drop it; a later gap or the end lowers it.
   task automatic send_beat(input sensor_beat_type beat);
      while (!steady_req && $urandom_range(99) < 25) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid             <= 1'b1;
      req_bus.kind              <= beat.kind;
      req_bus.oxygen_value      <= beat.oxygen;
      req_bus.saturation_value  <= beat.saturation;
      req_bus.temperature_value <= beat.temperature;
      req_bus.level_value       <= beat.level;
      req_bus.bucket_time       <= beat.stamp;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      beats_sent++;
   endtask

   // Stop offering and wait until every flush has its result. The checker's count
   // is registered, so look at it from the following edge on.
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int unsigned bucket_size;
      int unsigned random_base;
      int          i;
      bit          in_window;

      reset                     <= 1'b1;
      req_bus.valid             <= 1'b0;
      req_bus.kind              <= BEAT_SAMPLE;
      req_bus.oxygen_value      <= '0;
      req_bus.saturation_value  <= '0;
      req_bus.temperature_value <= '0;
      req_bus.level_value       <= '0;
      req_bus.bucket_time       <= '0;
      steady_rsp                <= 1'b0;
      hold_ticket               <= 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty flush straight out of reset.
      send_beat(make_flush(32'hFFFF_FFFF));
      // Single sample with every field at its top; oxygen, saturation and temperature clamp high.
      send_beat(make_sample(131071, 131071, 65535, 255));
      send_beat(make_flush(32'h0000_0000));
      // Single sample at the bottom; negative means go to zero.
      send_beat(make_sample(-131072, -131072, -65536, 0));
      send_beat(make_flush(32'h5555_AAAA));
      // Means of 1.5 and 0.5 round up; temperatures just outside the clamp.
      send_beat(make_sample(1, 0, -30001, 7));
      send_beat(make_sample(2, 1, 30001, 3));
      send_beat(make_flush(32'hAAAA_5555));
      // Values on and one past the output clamps.
      send_beat(make_sample(65000, 65500, 30000, 128));
      send_beat(make_sample(65001, 65501, -30000, 127));
      send_beat(make_flush(32'h0000_0001));
      // Empty again right after a full bucket.
      send_beat(make_flush(32'h8000_0000));
      // Level restarts at zero; oxygen sum of exactly zero.
      send_beat(make_sample(-5, -1, -1, 0));
      send_beat(make_sample(5, 2, 0, 0));
      send_beat(make_flush(32'h1234_5678));
      // Mean of 2.5 rounds to 3.
      send_beat(make_sample(2, 65535, 16, 1));
      send_beat(make_sample(3, 65536, -16, 2));
      send_beat(make_flush(32'hFEDC_BA98));
      settle();

      // Back-pressure: refuse results while flushes keep coming, so the output
      // register fills, a second aggregate waits behind it and the input stalls.
      hold_ticket <= hold_ticket + 1;
      for (i = 0; i < 8; i++) begin
         send_beat(rand_sample());
         send_beat(make_flush($urandom));
      end
      settle();

      // Randomized buckets: mostly short, some long enough to saturate the total.
      random_base = beats_sent;
      while (beats_sent - random_base < RANDOM_BEATS) begin
         in_window  = (beats_sent - random_base >= STEADY_FROM) &&
                      (beats_sent - random_base < STEADY_TO);
         steady_req = in_window;
         steady_rsp <= in_window;
         case ($urandom_range(24))
            0:       bucket_size = $urandom_range(300, 255);
            1, 2, 3: bucket_size = $urandom_range(60, 13);
            default: bucket_size = $urandom_range(12);
         endcase
         repeat (bucket_size) send_beat(rand_sample());
         send_beat(make_flush($urandom));
         if ($urandom_range(19) == 0) settle();
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Result side: random stalls, no stalls in steady stretches, and one long
   // hold-off counted here each time the stimulus raises the ticket.
   initial begin : receiver
      int unsigned hold_left;
      int unsigned tickets_seen;
      hold_left    = 0;
      tickets_seen = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_ticket != tickets_seen) begin
            tickets_seen = hold_ticket;
            hold_left    = HOLD_SPAN;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (steady_rsp) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= 25);
         end
      end
   end

   // Drop the run if neither channel moves a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= HANG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/smma_pkg.sv
rtl/core/smma_req_if.sv
rtl/core/smma_div.sv
rtl/core/sample_min_max_mean_aggregator.sv
verif/smma_beat_pkg.sv
verif/sample_min_max_mean_aggregator_checker.sv
verif/sample_min_max_mean_aggregator_test.sv
